### rtl/hqe_pkg.sv
// package for the histogram quantile engine
// shared constants and the controller/datapath command and status types
package hqe_pkg;
   localparam int NUM_BINS_DEF   = 256;
   localparam int COUNT_BITS_DEF = 16;
   localparam int TOTAL_BITS     = 24;
   localparam int SUM_BITS       = 32;
   localparam int VALUE_BITS     = 8;
   localparam int MEAN_BITS      = 16;
   localparam int SHARE_BITS     = 17;
   localparam int DIV_NUM_BITS   = 48;

   typedef struct packed {
      logic clear_wr;    // write zero at clear address
      logic ins_rd;      // read bin of insert value
      logic ins_wr;      // write back incremented bin
      logic scan_start;  // reset scan accumulators
      logic scan_rd;     // read bin at scan address
      logic scan_acc;    // accumulate the read bin
      logic div_start;   // start divider pass
      logic div_sel;     // 0 mean, 1 share
      logic div_step;    // one divider iteration
      logic div_cap;     // capture quotient
   } hqe_cmd_type;

   typedef struct packed {
      logic ins_ok;      // insert may be applied
      logic empty;       // total is zero
   } hqe_sts_type;
endpackage

### rtl/hqe_ram.sv
// generic simple dual port ram, one write and one read port, registered read
// no dependencies
module hqe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/hqe_datapath.sv
// datapath: bin memory, totals, quantile scan and serial divider
// uses hqe_pkg and hqe_ram
module hqe_datapath import hqe_pkg::*; #(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int AW = $clog2(NUM_BINS)
) (
   input  logic                  clock,
   input  hqe_cmd_type           cmd,
   output hqe_sts_type           sts,
   input  logic [AW-1:0]         addr,
   input  logic [VALUE_BITS-1:0] value,
   output logic [VALUE_BITS-1:0] q1_out,
   output logic [VALUE_BITS-1:0] med_out,
   output logic [VALUE_BITS-1:0] q3_out,
   output logic [MEAN_BITS-1:0]  mean_out,
   output logic [SHARE_BITS-1:0] share_out,
   output logic [TOTAL_BITS-1:0] total_out,
   input  logic                  reset
);
   localparam logic [COUNT_BITS-1:0] CountMax = '1;
   localparam logic [TOTAL_BITS-1:0] TotalMax = '1;

   logic [COUNT_BITS-1:0] rd_data, wr_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [AW-1:0]         ins_addr_ff;
   logic                  ins_ok;

   hqe_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_addr = cmd.ins_rd ? addr : addr;
   assign ins_ok  = (rd_data != CountMax) && (total_ff != TotalMax);
   assign wr_en   = cmd.clear_wr | (cmd.ins_wr & ins_ok);
   assign wr_addr = cmd.clear_wr ? addr : ins_addr_ff;
   assign wr_data = cmd.clear_wr ? '0 : rd_data + 1'b1;
   assign sts.ins_ok = ins_ok;
   assign sts.empty  = (total_ff == '0);

   // scan state
   logic [TOTAL_BITS-1:0] acc_ff, side_sel, t1, t2, t3;
   logic [TOTAL_BITS:0]   acc_next;
   logic [AW-1:0]         scan_idx_ff;
   logic [VALUE_BITS-1:0] q1_ff, med_ff, q3_ff;
   logic                  f1_ff, f2_ff, f3_ff;
   logic [TOTAL_BITS-1:0] le_ff, ge_ff;  // counts at or below, at or above query

   assign t1 = {2'b00, total_ff[TOTAL_BITS-1:2]};
   assign t2 = {1'b0, total_ff[TOTAL_BITS-1:1]};
   assign t3 = TOTAL_BITS'({2'b00, total_ff[TOTAL_BITS-1:2]} * 3);
   assign acc_next = {1'b0, acc_ff} + (TOTAL_BITS+1)'(rd_data);

   logic nz;
   assign nz = (rd_data != '0);
   logic [VALUE_BITS-1:0] idx8;
   assign idx8 = VALUE_BITS'(scan_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         sum_ff   <= '0;
      end else begin
         total_ff <= total_in;
         sum_ff   <= sum_in;
      end
      if (cmd.ins_rd) ins_addr_ff <= addr;
      if (cmd.scan_rd) scan_idx_ff <= addr;
      if (cmd.scan_start) begin
         acc_ff <= '0; le_ff <= '0; ge_ff <= '0;
         f1_ff <= 1'b0; f2_ff <= 1'b0; f3_ff <= 1'b0;
         q1_ff <= '0; med_ff <= '0; q3_ff <= '0;
      end else if (cmd.scan_acc) begin
         acc_ff <= acc_next[TOTAL_BITS-1:0];
         if (32'(scan_idx_ff) <= 32'(value))
            le_ff <= le_ff + TOTAL_BITS'(rd_data);
         if (32'(scan_idx_ff) >= 32'(value))
            ge_ff <= ge_ff + TOTAL_BITS'(rd_data);
         if (nz && !f1_ff && acc_next >= {1'b0, t1}) begin
            f1_ff <= 1'b1; q1_ff <= idx8;
         end
         if (nz && !f2_ff && acc_next >= {1'b0, t2}) begin
            f2_ff <= 1'b1; med_ff <= idx8;
         end
         if (nz && !f3_ff && acc_next >= {1'b0, t3}) begin
            f3_ff <= 1'b1; q3_ff <= idx8;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      sum_in   = sum_ff;
      if (cmd.ins_wr && ins_ok) begin
         total_in = total_ff + 1'b1;
         if (sum_ff > SUM_BITS'(32'hFFFF_FFFF) - SUM_BITS'(ins_addr_ff))
            sum_in = '1;
         else
            sum_in = sum_ff + SUM_BITS'(ins_addr_ff);
      end
   end
   assign side_sel = (value <= med_ff) ? le_ff : ge_ff;

   // restoring divider, one quotient bit a cycle while div_step is set, msb first
   logic [DIV_NUM_BITS-1:0] num_ff;
   logic [TOTAL_BITS:0]     rem_ff, rem_sh;
   logic [DIV_NUM_BITS-1:0] quo_ff;
   logic [TOTAL_BITS+1:0]   trial;
   assign rem_sh = {rem_ff[TOTAL_BITS-1:0], num_ff[DIV_NUM_BITS-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, total_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         num_ff <= cmd.div_sel ? {side_sel, 24'd0} >> 8 : {8'd0, sum_ff, 8'd0};
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[DIV_NUM_BITS-2:0], 1'b0};
         if (!trial[TOTAL_BITS+1]) begin
            rem_ff <= trial[TOTAL_BITS:0];
            quo_ff <= {quo_ff[DIV_NUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DIV_NUM_BITS-2:0], 1'b0};
         end
      end
      if (cmd.div_cap) begin
         if (cmd.div_sel) share_out <= quo_ff[SHARE_BITS-1:0];
         else mean_out <= quo_ff[MEAN_BITS-1:0];
      end
   end

   assign q1_out    = q1_ff;
   assign med_out   = med_ff;
   assign q3_out    = q3_ff;
   assign total_out = total_ff;
endmodule

### rtl/hqe_control.sv
// controller state machine: clear sweep, insert, scan, divide, respond
// uses hqe_pkg
module hqe_control import hqe_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int AW = $clog2(NUM_BINS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_empty,
   output hqe_cmd_type           cmd,
   input  hqe_sts_type           sts,
   output logic [AW-1:0]         addr,
   output logic [VALUE_BITS-1:0] value_q
);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_INS = 4'd2,
                          S_SCAN = 4'd3, S_LAST = 4'd4, S_DIVA = 4'd5,
                          S_DIVB = 4'd6, S_RESP = 4'd7;
   localparam logic [5:0] DivSteps = 6'(DIV_NUM_BITS);
   localparam logic [AW-1:0] LastBin = AW'(NUM_BINS - 1);

   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [5:0]            dc_ff, dc_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  empty_ff, empty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0; dc_ff <= '0; empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; dc_ff <= dc_in;
         empty_ff <= empty_in;
      end
      val_ff <= val_in;
   end

   logic in_range;
   assign in_range = 32'(req_value) < NUM_BINS;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; dc_in = dc_ff; val_in = val_ff;
      empty_in = empty_ff;
      cmd = '0; addr = cnt_ff;
      req_ready = 1'b0; rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastBin) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            addr = AW'(req_value);
            if (req_valid) begin
               val_in = req_value;
               if (!req_mode) begin
                  if (in_range) begin
                     cmd.ins_rd = 1'b1; state_in = S_INS;
                  end
               end else if (sts.empty) begin
                  empty_in = 1'b1; state_in = S_RESP;
               end else begin
                  empty_in = 1'b0; cmd.scan_start = 1'b1;
                  cnt_in = '0; state_in = S_SCAN;
               end
            end
         end
         S_INS: begin
            cmd.ins_wr = 1'b1; state_in = S_IDLE;
         end
         S_SCAN: begin
            // read at cnt, accumulate prior read next cycle
            cmd.scan_rd = 1'b1; addr = cnt_ff;
            cmd.scan_acc = (cnt_ff != '0) | (dc_ff[0]);
            dc_in = 6'd1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastBin) state_in = S_LAST;
         end
         S_LAST: begin
            cmd.scan_acc = 1'b1; cmd.div_start = 1'b1; cmd.div_sel = 1'b0;
            dc_in = '0; state_in = S_DIVA;
         end
         S_DIVA: begin
            cmd.div_step = 1'b1; dc_in = dc_ff + 1'b1;
            if (dc_ff == DivSteps - 1'b1) state_in = S_DIVB;
         end
         S_DIVB: begin
            // capture mean, then start the share pass
            if (dc_ff == DivSteps) begin
               cmd.div_cap = 1'b1; cmd.div_sel = 1'b0;
               dc_in = DivSteps + 1'b1;
            end else if (dc_ff == DivSteps + 1'b1) begin
               cmd.div_start = 1'b1; cmd.div_sel = 1'b1;
               dc_in = '0;
            end else begin
               cmd.div_step = 1'b1; cmd.div_sel = 1'b1; dc_in = dc_ff + 1'b1;
               if (dc_ff == DivSteps - 1'b1) state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!empty_ff && dc_ff == DivSteps) begin
               cmd.div_cap = 1'b1; cmd.div_sel = 1'b1; dc_in = '0;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
   assign rsp_empty = empty_ff;
   assign value_q = val_ff;
endmodule

### rtl/histogram_quantile_engine.sv
// insert: a bin read then its write back
// report: the result follows a scan of all bins on the ram read port, a mean
// divider pass and a share divider pass, each with its start and capture steps;
// an empty store answers the cycle after; the next word is accepted the cycle after
// the result is taken
// reset runs a clearing pass over all NUM_BINS bins before the first word is accepted
module histogram_quantile_engine import hqe_pkg::*; #(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_first_quartile,
   output logic [VALUE_BITS-1:0] rsp_middle_value,
   output logic [VALUE_BITS-1:0] rsp_third_quartile,
   output logic [MEAN_BITS-1:0]  rsp_mean_fixed,
   output logic [SHARE_BITS-1:0] rsp_share_fixed,
   output logic [TOTAL_BITS-1:0] rsp_sample_count,
   output logic                  rsp_empty_flag
);
   localparam int AW = $clog2(NUM_BINS);
   hqe_cmd_type cmd;
   hqe_sts_type sts;
   logic [AW-1:0] addr;
   logic [VALUE_BITS-1:0] value_q, q1, med, q3;
   logic [MEAN_BITS-1:0] mean;
   logic [SHARE_BITS-1:0] share;
   logic [TOTAL_BITS-1:0] total;
   logic empty;

   hqe_control #(.NUM_BINS(NUM_BINS)) u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_value(req_value), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_empty(empty), .cmd(cmd), .sts(sts),
      .addr(addr), .value_q(value_q)
   );
   hqe_datapath #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock(clock), .cmd(cmd), .sts(sts), .addr(addr), .value(value_q),
      .q1_out(q1), .med_out(med), .q3_out(q3),
      .mean_out(mean), .share_out(share), .total_out(total), .reset(reset)
   );
   assign rsp_empty_flag     = empty;
   assign rsp_first_quartile = empty ? '0 : q1;
   assign rsp_middle_value   = empty ? '0 : med;
   assign rsp_third_quartile = empty ? '0 : q3;
   assign rsp_mean_fixed     = empty ? '0 : mean;
   assign rsp_share_fixed    = empty ? '0 : share;
   assign rsp_sample_count   = empty ? '0 : total;
endmodule
